// ===== sv/trfb_pkg.sv =====
package trfb_pkg;

  localparam logic [7:0] DELIM_BYTE   = 8'h7E;
  localparam logic [7:0] CSUM_BASE    = 8'hFF;
  localparam logic [8:0] LEN_OVERHEAD = 9'd14;
  localparam logic [7:0] FRAME_TYPE_RESET = 8'h10;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam logic [QAW:0] QCOUNT_FULL = (QAW + 1)'(QDEPTH);

  typedef enum logic [1:0] {
    JOB_HDR,
    JOB_PAY,
    JOB_DROP
  } job_kind_t;

  typedef logic [4:0] step_t;

  // header job steps
  localparam step_t STEP_DELIM    = 5'd0;
  localparam step_t STEP_LEN_HI   = 5'd1;
  localparam step_t STEP_LEN_LO   = 5'd2;
  localparam step_t STEP_TYPE     = 5'd3;
  localparam step_t STEP_FID      = 5'd4;
  localparam step_t STEP_ADDR7    = 5'd5;
  localparam step_t STEP_ADDR6    = 5'd6;
  localparam step_t STEP_ADDR5    = 5'd7;
  localparam step_t STEP_ADDR4    = 5'd8;
  localparam step_t STEP_ADDR3    = 5'd9;
  localparam step_t STEP_ADDR2    = 5'd10;
  localparam step_t STEP_ADDR1    = 5'd11;
  localparam step_t STEP_ADDR0    = 5'd12;
  localparam step_t STEP_NET_HI   = 5'd13;
  localparam step_t STEP_NET_LO   = 5'd14;
  localparam step_t STEP_RADIUS   = 5'd15;
  localparam step_t STEP_OPTS     = 5'd16;
  localparam step_t STEP_HDR_CSUM = 5'd17;

  // payload job steps
  localparam step_t STEP_PAY_DATA = 5'd0;
  localparam step_t STEP_PAY_CSUM = 5'd1;

  typedef struct packed {
    job_kind_t   kind;
    logic        close;
    logic [8:0]  len;
    logic [63:0] dest_addr;
    logic [15:0] network_addr;
    logic [7:0]  frame_id;
    logic [7:0]  radius;
    logic [7:0]  tx_options;
    logic [7:0]  data_byte;
  } job_t;

endpackage

// ===== sv/trfb_ifs.sv =====
interface trfb_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] dest_addr;
  logic [15:0] network_addr;
  logic [7:0]  frame_id;
  logic [7:0]  radius;
  logic [7:0]  tx_options;
  logic [7:0]  payload_len;
  logic [7:0]  data_byte;

  modport source (output valid, cmd, dest_addr, network_addr, frame_id, radius,
                  tx_options, payload_len, data_byte, input ready);
  modport sink (input valid, cmd, dest_addr, network_addr, frame_id, radius,
                tx_options, payload_len, data_byte, output ready);
endinterface

interface trfb_frm_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       is_checksum;
  logic       dropped;

  modport source (output valid, out_byte, last_of_run, is_checksum, dropped,
                  input ready);
  modport sink (input valid, out_byte, last_of_run, is_checksum, dropped,
                output ready);
endinterface

interface trfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/tx_request_frame_builder.sv =====
// Accepted transactions enter the job queue; output bytes are registered from the queue head.
// Throughput: one input transaction per cycle while the two-entry job queue has room;
// bytes leave one per cycle while frm.ready does not stall the output; a header is 17 bytes
// (18 with an empty payload), a payload job 1 byte (2 when it closes the frame), a drop 1 byte.
// Reset (rst, synchronous): clears queue, frame state and output valid; frame type = 0x10.
module tx_request_frame_builder
  import trfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  trfb_req_if.sink   req,
  trfb_frm_if.source frm,
  trfb_cfg_if.sink   cfg
);

  logic [7:0] frame_type;
  logic       push;
  job_t       push_job;
  logic       full;
  logic       pop;
  job_t       head;
  logic       nonempty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type <= FRAME_TYPE_RESET;
    end else if (cfg.valid) begin
      frame_type <= cfg.data;
    end
  end

  trfb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  trfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  trfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .nonempty   (nonempty),
    .frame_type (frame_type),
    .pop        (pop),
    .frm        (frm)
  );

endmodule

// ===== sv/trfb_front.sv =====
module trfb_front
  import trfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  trfb_req_if.sink         req,
  input  logic             full,
  output logic             push,
  output job_t             push_job
);

  logic       frame_open;
  logic       frame_open_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;

  assign req.ready = !full;
  assign push      = req.valid && !full;

  always_comb begin
    push_job.dest_addr    = req.dest_addr;
    push_job.network_addr = req.network_addr;
    push_job.frame_id     = req.frame_id;
    push_job.radius       = req.radius;
    push_job.tx_options   = req.tx_options;
    push_job.data_byte    = req.data_byte;
    push_job.len          = {1'b0, req.payload_len} + LEN_OVERHEAD;
    frame_open_next       = frame_open;
    bytes_left_next       = bytes_left;
    if (!req.cmd) begin
      push_job.kind   = JOB_HDR;
      push_job.close  = (req.payload_len == 8'd0);
      frame_open_next = (req.payload_len != 8'd0);
      bytes_left_next = req.payload_len;
    end else if (!frame_open) begin
      push_job.kind  = JOB_DROP;
      push_job.close = 1'b0;
    end else begin
      push_job.kind   = JOB_PAY;
      push_job.close  = (bytes_left == 8'd1);
      frame_open_next = (bytes_left != 8'd1);
      bytes_left_next = bytes_left - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 8'd0;
    end else if (push) begin
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ===== sv/trfb_queue.sv =====
module trfb_queue
  import trfb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic nonempty
);

  job_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full     = (count == QCOUNT_FULL);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QAW + 1)'(1);
        2'b01:   count <= count - (QAW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/trfb_back.sv =====
module trfb_back
  import trfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       nonempty,
  input  logic [7:0] frame_type,
  output logic       pop,
  trfb_frm_if.source frm
);

  step_t      step;
  step_t      step_next;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic       advance;
  logic [7:0] byte_sel;
  logic       summed;
  logic       csum_sel;
  logic       drop_sel;
  logic       done;

  assign advance = nonempty && (!frm.valid || frm.ready);
  assign pop     = advance && done;

  always_comb begin
    byte_sel = 8'd0;
    summed   = 1'b0;
    csum_sel = 1'b0;
    drop_sel = 1'b0;
    done     = 1'b0;
    case (head.kind)
      JOB_HDR: begin
        summed = (step >= STEP_TYPE) && (step <= STEP_OPTS);
        case (step)
          STEP_DELIM:    byte_sel = DELIM_BYTE;
          STEP_LEN_HI:   byte_sel = {7'd0, head.len[8]};
          STEP_LEN_LO:   byte_sel = head.len[7:0];
          STEP_TYPE:     byte_sel = frame_type;
          STEP_FID:      byte_sel = head.frame_id;
          STEP_ADDR7:    byte_sel = head.dest_addr[63:56];
          STEP_ADDR6:    byte_sel = head.dest_addr[55:48];
          STEP_ADDR5:    byte_sel = head.dest_addr[47:40];
          STEP_ADDR4:    byte_sel = head.dest_addr[39:32];
          STEP_ADDR3:    byte_sel = head.dest_addr[31:24];
          STEP_ADDR2:    byte_sel = head.dest_addr[23:16];
          STEP_ADDR1:    byte_sel = head.dest_addr[15:8];
          STEP_ADDR0:    byte_sel = head.dest_addr[7:0];
          STEP_NET_HI:   byte_sel = head.network_addr[15:8];
          STEP_NET_LO:   byte_sel = head.network_addr[7:0];
          STEP_RADIUS:   byte_sel = head.radius;
          STEP_OPTS:     byte_sel = head.tx_options;
          STEP_HDR_CSUM: byte_sel = CSUM_BASE - sum;
          default:       byte_sel = 8'd0;
        endcase
        csum_sel = (step == STEP_HDR_CSUM);
        done     = csum_sel || ((step == STEP_OPTS) && !head.close);
      end
      JOB_PAY: begin
        if (step == STEP_PAY_DATA) begin
          byte_sel = head.data_byte;
          summed   = 1'b1;
          done     = !head.close;
        end else begin
          byte_sel = CSUM_BASE - sum;
          csum_sel = 1'b1;
          done     = 1'b1;
        end
      end
      JOB_DROP: begin
        drop_sel = 1'b1;
        done     = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_next = done ? '0 : step + step_t'(1);
    if ((head.kind == JOB_HDR) && (step == STEP_DELIM)) begin
      sum_next = 8'd0;
    end else if (summed) begin
      sum_next = sum + byte_sel;
    end else begin
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      sum       <= 8'd0;
      frm.valid <= 1'b0;
    end else begin
      if (advance) begin
        step <= step_next;
        sum  <= sum_next;
      end
      if (advance) begin
        frm.valid <= 1'b1;
      end else if (frm.ready) begin
        frm.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frm.out_byte    <= byte_sel;
      frm.last_of_run <= done;
      frm.is_checksum <= csum_sel;
      frm.dropped     <= drop_sel;
    end
  end

endmodule
